// ===== hw/rtl/rdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg: shared definitions of the radix digit converter
// Widths, register indexes, reset values and the controller/datapath types.
// ----------------------------------------------------------------------------
package rdc_pkg;

   localparam int ValueWidth       = 64;
   localparam int BitCntWidth      = $clog2(ValueWidth);
   localparam int DigitWidth       = 4;
   localparam int RadixWidth       = 5;
   localparam int CharWidth        = 8;
   localparam int CsrIndexWidth    = 2;
   localparam int MaxBase          = 16;
   localparam int DefaultMaxDigits = 64;

   localparam logic [RadixWidth-1:0] MinRadix      = RadixWidth'(2);
   localparam logic [RadixWidth-1:0] MaxRadix      = RadixWidth'(MaxBase);
   localparam logic [RadixWidth-1:0] BaseSizeReset = RadixWidth'(10);

   // Characters "01234567" and "89", lowest byte holds the lowest digit.
   localparam logic [ValueWidth-1:0] DigitCharsLowReset  = 64'h3736_3534_3332_3130;
   localparam logic [ValueWidth-1:0] DigitCharsHighReset = 64'h0000_0000_0000_3938;

   typedef enum logic [CsrIndexWidth-1:0] {
      CsrBaseSize       = 2'd0,
      CsrDigitCharsLow  = 2'd1,
      CsrDigitCharsHigh = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      StIdle,
      StConvert,
      StSkip,
      StEmit
   } ctrl_state_type;

   typedef struct packed {
      logic load;   // capture a new value and clear the digit array
      logic step;   // fold one value bit into the digit array
      logic shift;  // move the digit array one place toward the top
      logic emit;   // load the top digit's character into the output register
      logic last;   // the emitted character is the final one
   } dp_cmd_type;

   typedef struct packed {
      logic top_zero;  // the top digit is zero
      logic overflow;  // the value needs more digits than the array holds
      logic out_free;  // the output register can take a beat this cycle
   } dp_status_type;

endpackage

// ===== hw/rtl/radix_digit_converter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter_unit: unsigned integer to digit characters
// Converts a 64-bit unsigned value to its digits in a base from 2 to 16 and
// sends one character beat per digit, most significant digit first.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Beat contents
//   req_      in         req_valid/req_stall  req_value (64 bits)
//   rsp_      out        rsp_valid/rsp_stall  rsp_digit_char (8), rsp_last_digit
//   csr_      in         csr_valid/csr_ready  csr_index (2), csr_data (64)
//
// An item is first converted, which folds one value bit per cycle into the
// base-b digit array; then the array is walked from its top, one digit a
// cycle, first over leading zeros and then emitting, where output stalls
// hold the walk.
// The next item is accepted once the last beat sits in the output register.
// Reset is synchronous and active high; it restores the registers to base 10
// and the characters "0123456789" and empties the output register.
// The configuration port is always ready and must only be written while the
// block is idle.
//
module radix_digit_converter_unit #(
   parameter int MaxDigits = rdc_pkg::DefaultMaxDigits
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rdc_pkg::ValueWidth-1:0]      req_value,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rdc_pkg::CharWidth-1:0]       rsp_digit_char,
   output logic                                rsp_last_digit,
   // Configuration port
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rdc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [rdc_pkg::ValueWidth-1:0]      csr_data
);
   import rdc_pkg::*;

   logic [RadixWidth-1:0] base_size_ff, base_size_in;
   logic [ValueWidth-1:0] chars_low_ff, chars_low_in;
   logic [ValueWidth-1:0] chars_high_ff, chars_high_in;
   logic [RadixWidth-1:0] radix;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   // Register writes; an index outside the register list is dropped.
   always_comb begin
      base_size_in  = base_size_ff;
      chars_low_in  = chars_low_ff;
      chars_high_in = chars_high_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CsrBaseSize:       base_size_in  = csr_data[RadixWidth-1:0];
            CsrDigitCharsLow:  chars_low_in  = csr_data;
            CsrDigitCharsHigh: chars_high_in = csr_data;
            default:           base_size_in  = base_size_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_size_ff  <= BaseSizeReset;
         chars_low_ff  <= DigitCharsLowReset;
         chars_high_ff <= DigitCharsHighReset;
      end else begin
         base_size_ff  <= base_size_in;
         chars_low_ff  <= chars_low_in;
         chars_high_ff <= chars_high_in;
      end
   end

   // A base size below two counts as two, one above the table size as the
   // table size.
   always_comb begin
      if (base_size_ff < MinRadix) begin
         radix = MinRadix;
      end else if (base_size_ff > MaxRadix) begin
         radix = MaxRadix;
      end else begin
         radix = base_size_ff;
      end
   end

   rdc_ctrl #(
      .MaxDigits (MaxDigits)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   rdc_datapath #(
      .MaxDigits (MaxDigits)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .radix            (radix),
      .digit_chars_low  (chars_low_ff),
      .digit_chars_high (chars_high_ff),
      .req_value        (req_value),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_digit_char   (rsp_digit_char),
      .rsp_last_digit   (rsp_last_digit)
   );

endmodule

// ===== hw/rtl/rdc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_ctrl: sequencer of the radix digit converter
// Steps the datapath through conversion, leading-zero skip and emission.
// ----------------------------------------------------------------------------
module rdc_ctrl #(
   parameter int MaxDigits = rdc_pkg::DefaultMaxDigits
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output rdc_pkg::dp_cmd_type   cmd,
   input  rdc_pkg::dp_status_type status
);
   import rdc_pkg::*;

   localparam int RemWidth = $clog2(MaxDigits + 1);
   localparam logic [BitCntWidth-1:0] LastBit   = BitCntWidth'(ValueWidth - 1);
   localparam logic [RemWidth-1:0]    FullCount = RemWidth'(MaxDigits);
   localparam logic [RemWidth-1:0]    OneLeft   = RemWidth'(1);

   ctrl_state_type          state_ff, state_in;
   logic [BitCntWidth-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [RemWidth-1:0]     remain_ff, remain_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= StIdle;
         bit_cnt_ff <= '0;
         remain_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         remain_ff  <= remain_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      bit_cnt_in = bit_cnt_ff;
      remain_in  = remain_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      case (state_ff)
         StIdle: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load   = 1'b1;
               bit_cnt_in = '0;
               state_in   = StConvert;
            end
         end
         StConvert: begin
            cmd.step   = 1'b1;
            bit_cnt_in = bit_cnt_ff + BitCntWidth'(1);
            if (bit_cnt_ff == LastBit) begin
               remain_in = FullCount;
               state_in  = StSkip;
            end
         end
         StSkip: begin
            // Leading zeros are dropped, but never the last digit and never
            // when the value needed more digits than the array holds.
            if (!status.overflow && status.top_zero && remain_ff != OneLeft) begin
               cmd.shift = 1'b1;
               remain_in = remain_ff - OneLeft;
            end else begin
               state_in = StEmit;
            end
         end
         StEmit: begin
            if (status.out_free) begin
               cmd.emit  = 1'b1;
               cmd.shift = 1'b1;
               cmd.last  = (remain_ff == OneLeft);
               remain_in = remain_ff - OneLeft;
               if (remain_ff == OneLeft) begin
                  state_in = StIdle;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

endmodule

// ===== hw/rtl/rdc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_datapath: digit array and output register of the radix digit converter
// Doubles the base-b digit array and adds one value bit per step.
// ----------------------------------------------------------------------------
module rdc_datapath #(
   parameter int MaxDigits = rdc_pkg::DefaultMaxDigits
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rdc_pkg::dp_cmd_type                 cmd,
   output rdc_pkg::dp_status_type              status,
   input  logic [rdc_pkg::RadixWidth-1:0]      radix,
   input  logic [rdc_pkg::ValueWidth-1:0]      digit_chars_low,
   input  logic [rdc_pkg::ValueWidth-1:0]      digit_chars_high,
   input  logic [rdc_pkg::ValueWidth-1:0]      req_value,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [rdc_pkg::CharWidth-1:0]       rsp_digit_char,
   output logic                                rsp_last_digit
);
   import rdc_pkg::*;

   function automatic logic [CharWidth-1:0] char_of_digit(
      input logic [DigitWidth-1:0] digit,
      input logic [ValueWidth-1:0] low,
      input logic [ValueWidth-1:0] high
   );
      logic [2*ValueWidth-1:0] char_table;
      char_table = {high, low};
      return char_table[{digit, 3'b000} +: CharWidth];
   endfunction

   logic [ValueWidth-1:0] value_ff, value_in;
   logic [DigitWidth-1:0] lanes_ff [MaxDigits];
   logic [DigitWidth-1:0] lanes_in [MaxDigits];
   logic                  overflow_ff, overflow_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0]  rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [RadixWidth-1:0] doubled  [MaxDigits];
   logic [RadixWidth-1:0] reduced  [MaxDigits];
   logic [MaxDigits-1:0]  gen;
   logic [MaxDigits-1:0]  gen_or_prop;
   logic [MaxDigits:0]    carry_sum;
   logic [MaxDigits:0]    carries;
   logic [DigitWidth-1:0] top_digit;

   // A lane generates a carry when twice its digit reaches the radix and
   // passes the incoming carry on when twice its digit is one short of it.
   // The carries across all lanes then come out of one wide addition.
   always_comb begin
      for (int i = 0; i < MaxDigits; i++) begin
         doubled[i]     = {lanes_ff[i], 1'b0};
         gen[i]         = (doubled[i] >= radix);
         gen_or_prop[i] = gen[i] | ((doubled[i] + RadixWidth'(1)) == radix);
      end
      carry_sum = {1'b0, gen} + {1'b0, gen_or_prop}
                + {{MaxDigits{1'b0}}, value_ff[ValueWidth-1]};
      carries   = carry_sum ^ {1'b0, gen} ^ {1'b0, gen_or_prop};
      for (int i = 0; i < MaxDigits; i++) begin
         reduced[i] = (doubled[i] | RadixWidth'(carries[i]))
                    - (carries[i+1] ? radix : RadixWidth'(0));
      end
   end

   assign top_digit = lanes_ff[MaxDigits-1];

   always_comb begin
      value_in     = value_ff;
      overflow_in  = overflow_ff;
      lanes_in     = lanes_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.load) begin
         value_in    = req_value;
         overflow_in = 1'b0;
         for (int i = 0; i < MaxDigits; i++) begin
            lanes_in[i] = '0;
         end
      end else if (cmd.step) begin
         value_in    = {value_ff[ValueWidth-2:0], 1'b0};
         overflow_in = overflow_ff | carries[MaxDigits];
         for (int i = 0; i < MaxDigits; i++) begin
            lanes_in[i] = reduced[i][DigitWidth-1:0];
         end
      end else if (cmd.shift) begin
         lanes_in[0] = '0;
         for (int i = 1; i < MaxDigits; i++) begin
            lanes_in[i] = lanes_ff[i-1];
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = char_of_digit(top_digit, digit_chars_low, digit_chars_high);
         rsp_last_in  = cmd.last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      lanes_ff    <= lanes_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.top_zero = (top_digit == '0);
   assign status.overflow = overflow_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last_digit = rsp_last_ff;

endmodule

// ===== hw/rtl/rdc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_checker: port-level checks of the radix digit converter
// Tracks items in flight and checks beats against them.
// ----------------------------------------------------------------------------
module rdc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_digit_char,
   input logic       rsp_last_digit
);

   logic       req_beat;
   logic       rsp_beat;
   logic       last_beat;
   logic [1:0] pending_ff, pending_in;

   assign req_beat  = req_valid && !req_stall;
   assign rsp_beat  = rsp_valid && !rsp_stall;
   assign last_beat = rsp_beat && rsp_last_digit;

   // Items accepted whose final beat has not yet been taken.
   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !last_beat) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_beat && last_beat) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_beat_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> (pending_ff != 2'd0))
      else $error("result beat without an accepted item");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> req_stall)
      else $error("input accepted again right after an accept");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stalled_beat_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_digit_char) && $stable(rsp_last_digit)))
      else $error("stalled result beat changed");

endmodule

bind radix_digit_converter_unit rdc_checker u_checker (.*);

// ===== sim/radix_digit_converter_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter_unit_test: self-checking bench of the digit converter
// Drives 64-bit values through the request channel under a series of radix
// and character-table settings, expects every digit beat, typed in or
// predicted, and compares each received beat field by field, with random
// idling on both sides and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module radix_digit_converter_unit_test;

   import rdc_pkg::*;

   // Index 3 has no register behind it; writes to it must have no effect.
   localparam logic [CsrIndexWidth-1:0] CsrUnused = 2'd3;

   localparam logic [ValueWidth-1:0] AllOnes      = {ValueWidth{1'b1}};
   localparam logic [ValueWidth-1:0] TopBit       = 64'h8000_0000_0000_0000;
   localparam logic [ValueWidth-1:0] HexUpperHigh = 64'h4645_4443_4241_3938;
   localparam logic [ValueWidth-1:0] LowerAlpha   = 64'h6867_6665_6463_6261;

   localparam int RandomPhases   = 8;
   localparam int ItemsPerPhase  = 55;
   localparam int LongHoldCycles = 600;

   typedef enum logic {
      RowItem,
      RowCsr
   } row_kind_type;

   // One directed step: either a value to convert or a register write. For a
   // value, a non-empty digit string is the expected output typed in by hand;
   // an empty string leaves the expectation to the predictor.
   typedef struct {
      row_kind_type             kind;
      logic [CsrIndexWidth-1:0] index;
      logic [ValueWidth-1:0]    data;
      string                    digits;
   } stim_row_type;

   typedef struct packed {
      logic [CharWidth-1:0] digit_char;
      logic                 last_digit;
   } digit_beat_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [ValueWidth-1:0]    req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [CharWidth-1:0]     rsp_digit_char;
   logic                     rsp_last_digit;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [ValueWidth-1:0]    csr_data = '0;

   // The bench's own copy of the block's registers, changed only when a
   // write is accepted.
   logic [RadixWidth-1:0]    radix_setting;
   logic [ValueWidth-1:0]    chars_low_setting;
   logic [ValueWidth-1:0]    chars_high_setting;

   // Digit beats that accepted values are still owed, oldest first.
   digit_beat_type           pending_digits[$];

   int                       mismatch_count = 0;
   int                       values_sent = 0;
   int                       beats_checked = 0;
   int                       csr_writes = 0;

   // Phases marked calm run without any random idling on either side.
   bit                       calm_phase = 1'b0;
   // Set by the stimulus to ask the receiver for one long hold-off.
   int unsigned              rx_hold_request = 0;

   radix_digit_converter_unit #(
      .MaxDigits(DefaultMaxDigits)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs. The slowest correct run, with every
   // value at 64 digits and every beat stalled its longest, stays far below.
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Predictor: divides the value down by the effective radix, keeping the
   // remainders least significant first, then queues their characters most
   // significant first with the final one marked as last.
   function automatic void predict_digits(input logic [ValueWidth-1:0] value);
      logic [RadixWidth-1:0]   radix;
      logic [ValueWidth-1:0]   quotient;
      logic [DigitWidth-1:0]   digit;
      logic [DigitWidth-1:0]   digit_stack[DefaultMaxDigits];
      logic [2*ValueWidth-1:0] char_table;
      digit_beat_type          beat;
      int                      count;
      int                      k;
      radix = radix_setting;
      // Radix values below two and above sixteen are clamped to the range.
      if (radix < MinRadix) radix = MinRadix;
      if (radix > MaxRadix) radix = MaxRadix;
      char_table = {chars_high_setting, chars_low_setting};
      quotient = value;
      count = 0;
      // Zero still produces one digit, hence the do-while.
      do begin
         digit = DigitWidth'(quotient % ValueWidth'(radix));
         quotient = quotient / ValueWidth'(radix);
         if (count < DefaultMaxDigits) begin
            digit_stack[count] = digit;
            count++;
         end
      end while (quotient != 0);
      for (k = count - 1; k >= 0; k--) begin
         beat.digit_char = char_table[8*digit_stack[k] +: CharWidth];
         beat.last_digit = (k == 0);
         pending_digits.push_back(beat);
      end
   endfunction

   function automatic stim_row_type item_row(input logic [ValueWidth-1:0] value,
                                             input string digits);
      stim_row_type row;
      row.kind   = RowItem;
      row.index  = '0;
      row.data   = value;
      row.digits = digits;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [CsrIndexWidth-1:0] index,
                                            input logic [ValueWidth-1:0] data);
      stim_row_type row;
      row.kind   = RowCsr;
      row.index  = index;
      row.data   = data;
      row.digits = "";
      return row;
   endfunction

   // Offers one value and waits for the block to take it. The expectation is
   // queued at the accepting edge, before any of its beats can appear. When
   // the drawn gap is zero, valid stays high for the next call to reuse.
   task automatic send_value(input logic [ValueWidth-1:0] value, input string digits);
      digit_beat_type beat;
      int             gap;
      int             i;
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      if (digits.len() == 0) begin
         predict_digits(value);
      end else begin
         for (i = 0; i < digits.len(); i++) begin
            beat.digit_char = digits[i];
            beat.last_digit = (i == digits.len() - 1);
            pending_digits.push_back(beat);
         end
      end
      values_sent++;
      gap = calm_phase ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Register writes happen only with the block idle: every owed beat has
   // arrived, and then the bench idles before it writes.
   task automatic write_csr(input logic [CsrIndexWidth-1:0] index,
                            input logic [ValueWidth-1:0] data);
      req_valid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CsrBaseSize:       radix_setting      = data[RadixWidth-1:0];
         CsrDigitCharsLow:  chars_low_setting  = data;
         CsrDigitCharsHigh: chars_high_setting = data;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic check_digit_beat(input logic [CharWidth-1:0] digit_char,
                                   input logic last_digit);
      digit_beat_type want;
      if (pending_digits.size() == 0) begin
         $error("Digit beat 0x%02h arrived with no conversion pending", digit_char);
         mismatch_count++;
      end else begin
         want = pending_digits.pop_front();
         if (want.digit_char !== digit_char) begin
            $error("digit_char: expected 0x%02h, actual 0x%02h", want.digit_char,
                   digit_char);
            mismatch_count++;
         end
         if (want.last_digit !== last_digit) begin
            $error("last_digit: expected %0b, actual %0b", want.last_digit, last_digit);
            mismatch_count++;
         end
         beats_checked++;
      end
   endtask

   // Receiver. After each accepted beat it draws how many cycles the next
   // beat has to wait; the count runs down only while a beat is on offer, so
   // the first beat of a conversion gets stalled as often as the rest. A long
   // hold-off, when asked for, is counted here in plain cycles.
   initial begin : digit_receiver
      int unsigned wait_left;
      int unsigned hold_left;
      logic        took;
      wait_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         took = !reset && rsp_valid && !rsp_stall;
         if (took) check_digit_beat(rsp_digit_char, rsp_last_digit);
         if (rx_hold_request != 0) begin
            hold_left = rx_hold_request;
            rx_hold_request = 0;
         end
         if (took) begin
            wait_left = calm_phase ? 0 : $urandom_range(0, 3);
         end else if (rsp_valid && wait_left != 0) begin
            wait_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (wait_left != 0);
         end
      end
   end

   // Stimulus: a directed table first, then random phases, each under a
   // fresh radix and character table.
   initial begin : stimulus
      stim_row_type          directed_rows[$];
      stim_row_type          row;
      logic [ValueWidth-1:0] raw;
      logic [ValueWidth-1:0] base_data;
      int                    phase;
      int                    n;
      int                    drain_cycles;

      radix_setting      = BaseSizeReset;
      chars_low_setting  = DigitCharsLowReset;
      chars_high_setting = DigitCharsHighReset;

      // Reset state: base ten with the characters 0 to 9.
      directed_rows.push_back(item_row(64'd0, "0"));
      directed_rows.push_back(item_row(64'd1, "1"));
      directed_rows.push_back(item_row(64'd9, "9"));
      directed_rows.push_back(item_row(64'd10, "10"));
      directed_rows.push_back(item_row(AllOnes, "18446744073709551615"));
      // Hexadecimal with the upper half of the table filled in.
      directed_rows.push_back(csr_row(CsrDigitCharsHigh, HexUpperHigh));
      directed_rows.push_back(csr_row(CsrBaseSize, 64'd16));
      directed_rows.push_back(item_row(AllOnes, "FFFFFFFFFFFFFFFF"));
      directed_rows.push_back(item_row(64'h0123_4567_89AB_CDEF, "123456789ABCDEF"));
      directed_rows.push_back(item_row(TopBit, "8000000000000000"));
      // Binary: the full 64 digits come out of the widest values.
      directed_rows.push_back(csr_row(CsrBaseSize, 64'd2));
      directed_rows.push_back(item_row(64'd0, "0"));
      directed_rows.push_back(item_row(64'd5, "101"));
      directed_rows.push_back(item_row(AllOnes, ""));
      directed_rows.push_back(item_row(TopBit, ""));
      // Radix settings of zero and one behave as binary.
      directed_rows.push_back(csr_row(CsrBaseSize, 64'd0));
      directed_rows.push_back(item_row(64'd6, "110"));
      directed_rows.push_back(csr_row(CsrBaseSize, 64'd1));
      directed_rows.push_back(item_row(64'd2, "10"));
      // Settings above sixteen behave as sixteen; only the low five bits of
      // the write data count.
      directed_rows.push_back(csr_row(CsrBaseSize, AllOnes));
      directed_rows.push_back(item_row(64'd255, "FF"));
      directed_rows.push_back(csr_row(CsrBaseSize, 64'd17));
      directed_rows.push_back(item_row(64'd16, "10"));
      // A write to the unused index must leave the radix and table alone.
      directed_rows.push_back(csr_row(CsrUnused, 64'd0));
      directed_rows.push_back(item_row(64'd31, "1F"));
      // Octal with letters for the lower digits.
      directed_rows.push_back(csr_row(CsrDigitCharsLow, LowerAlpha));
      directed_rows.push_back(csr_row(CsrBaseSize, 64'd8));
      directed_rows.push_back(item_row(AllOnes, ""));
      directed_rows.push_back(item_row(64'd8, "ba"));
      // Base three, again with junk in the upper data bits.
      directed_rows.push_back(csr_row(CsrBaseSize, 64'hFFFF_FFFF_FFFF_FFE3));
      directed_rows.push_back(item_row(AllOnes, ""));
      directed_rows.push_back(item_row(64'd0, "a"));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == RowCsr) begin
            write_csr(row.index, row.data);
         end else begin
            send_value(row.data, row.digits);
         end
      end

      for (phase = 0; phase < RandomPhases; phase++) begin
         // The radix extremes get phases of their own; the rest are random,
         // now and then outside the legal range.
         base_data = {$urandom, $urandom};
         case (phase)
            0:       base_data[RadixWidth-1:0] = 5'd2;
            1:       base_data[RadixWidth-1:0] = 5'd16;
            4:       base_data[RadixWidth-1:0] = 5'd31;
            6:       base_data[RadixWidth-1:0] = 5'd0;
            default: base_data[RadixWidth-1:0] = ($urandom_range(0, 3) == 0) ?
                                                 5'($urandom_range(0, 31)) :
                                                 5'($urandom_range(2, 16));
         endcase
         write_csr(CsrDigitCharsLow, {$urandom, $urandom});
         write_csr(CsrDigitCharsHigh, {$urandom, $urandom});
         write_csr(CsrBaseSize, base_data);
         if (phase % 3 == 1) write_csr(CsrUnused, {$urandom, $urandom});

         // Phase 2 runs the sender flat out into a long output hold-off so
         // the block backs up and stalls its input; phase 5 has no idling.
         calm_phase = (phase == 2 || phase == 5);
         if (phase == 2) rx_hold_request = LongHoldCycles;

         for (n = 0; n < ItemsPerPhase; n++) begin
            // Half are values of random length, so every digit count shows up,
            // plus zero, all ones and full-width random values.
            raw = {$urandom, $urandom};
            case ($urandom_range(0, 9))
               0:       raw = '0;
               1:       raw = AllOnes;
               2, 3, 4: ;
               default: raw = raw >> $urandom_range(1, 63);
            endcase
            send_value(raw, "");
         end
         calm_phase = 1'b0;
      end
      req_valid <= 1'b0;

      // Let the last conversions drain, then watch a while for stray beats.
      drain_cycles = 0;
      while (pending_digits.size() != 0 && drain_cycles < 20000) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (pending_digits.size() != 0) begin
         $error("%0d expected digit beats never arrived", pending_digits.size());
         mismatch_count++;
      end
      repeat (140) @(posedge clock);

      $display("Converted %0d values into %0d checked digit beats", values_sent,
               beats_checked);
      $display("Covered %0d register writes across radix and character settings",
               csr_writes);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== radix_digit_converter_unit.f =====
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_ctrl.sv
hw/rtl/rdc_datapath.sv
hw/rtl/radix_digit_converter_unit.sv
hw/rtl/rdc_checker.sv
sim/radix_digit_converter_unit_test.sv
